### src/crs_pkg.sv
// Shared types, codes and sizes of the Catmull-Rom curve sampler.
`default_nettype none
package crs_pkg;

    localparam int MAX_POINTS  = 64;
    localparam int ADDR_W      = 6;
    localparam int CNT_W       = 7;
    localparam int MAX_SEG_SMP = 32;
    localparam int COORD_W     = 32;
    // Horner accumulator: coefficients reach about 12 * 2^31, partial sums about 24 * 2^31
    localparam int ACC_W       = 40;
    localparam int T_W         = 16;

    // opcodes
    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_SAMPLE = 2'd2;
    localparam logic [1:0] OP_NOP    = 2'd3;

    // configuration register indexes
    localparam logic CFG_CLOSED = 1'b0;
    localparam logic CFG_SPS    = 1'b1;

    // Horner step selects the coefficient that is added
    localparam logic [1:0] STEP_B  = 2'd0;
    localparam logic [1:0] STEP_A  = 2'd1;
    localparam logic [1:0] STEP_P1 = 2'd2;

    typedef struct packed {
        logic [1:0]                opcode;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
    } t_in_beat;

    typedef struct packed {
        logic signed [COORD_W-1:0] sample_x;
        logic signed [COORD_W-1:0] sample_y;
        logic signed [COORD_W-1:0] sample_z;
        logic                      last_sample;
        logic                      exhausted;
    } t_out_beat;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } t_point;

    typedef struct packed {
        logic       shift;
        logic       coef;
        logic       mul;
        logic       acc;
        logic [1:0] step;
    } t_lane_ctl;

endpackage
`default_nettype wire

### src/crs_store.sv
// Control point store: three coordinate memories, one write and one read port.
`default_nettype none
module crs_store (
    input  wire                          i_clk,
    input  wire                          i_we,
    input  wire  [crs_pkg::ADDR_W-1:0]   i_waddr,
    input  wire  crs_pkg::t_point        i_wdata,
    input  wire                          i_re,
    input  wire  [crs_pkg::ADDR_W-1:0]   i_raddr,
    output crs_pkg::t_point              o_rdata
);
    logic [crs_pkg::COORD_W-1:0] r_mem_x [crs_pkg::MAX_POINTS];
    logic [crs_pkg::COORD_W-1:0] r_mem_y [crs_pkg::MAX_POINTS];
    logic [crs_pkg::COORD_W-1:0] r_mem_z [crs_pkg::MAX_POINTS];
    crs_pkg::t_point             r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem_x[i_waddr] <= i_wdata.x;
            r_mem_y[i_waddr] <= i_wdata.y;
            r_mem_z[i_waddr] <= i_wdata.z;
        end
    end

    // registered read port, holds between reads
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata.x <= r_mem_x[i_raddr];
            r_rdata.y <= r_mem_y[i_raddr];
            r_rdata.z <= r_mem_z[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

### src/crs_tdiv.sv
// Serial divider for t = k * 65536 / s, one quotient bit per cycle.
`default_nettype none
module crs_tdiv (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_start,
    input  wire  [5:0]                 i_k,
    input  wire  [5:0]                 i_s,
    output logic [crs_pkg::T_W-1:0]    o_q,
    output logic                       o_busy
);
    logic [4:0]              r_cnt, n_cnt;
    logic [5:0]              r_rem, n_rem;
    logic [5:0]              r_s;
    logic [crs_pkg::T_W-1:0] r_q, n_q;
    logic [6:0]              rem2;

    // k < s, so the remainder stays below s
    always_comb begin
        rem2  = {r_rem, 1'b0};
        n_cnt = r_cnt;
        n_rem = r_rem;
        n_q   = r_q;
        if (r_cnt != 5'd0) begin
            n_cnt = r_cnt - 5'd1;
            if (rem2 >= {1'b0, r_s}) begin
                n_rem = 6'(rem2 - {1'b0, r_s});
                n_q   = {r_q[crs_pkg::T_W-2:0], 1'b1};
            end else begin
                n_rem = rem2[5:0];
                n_q   = {r_q[crs_pkg::T_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 5'd0;
        end else if (i_start) begin
            r_cnt <= 5'(crs_pkg::T_W);
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_k;
            r_s   <= i_s;
            r_q   <= '0;
        end else begin
            r_rem <= n_rem;
            r_q   <= n_q;
        end
    end

    assign o_q    = r_q;
    assign o_busy = (r_cnt != 5'd0);
endmodule
`default_nettype wire

### src/crs_lane.sv
// One coordinate lane: neighbor window, cubic coefficients and Horner evaluation.
`default_nettype none
module crs_lane (
    input  wire                               i_clk,
    input  wire  crs_pkg::t_lane_ctl          i_ctl,
    input  wire  signed [crs_pkg::COORD_W-1:0] i_point,
    input  wire  [crs_pkg::T_W-1:0]           i_t,
    output logic signed [crs_pkg::COORD_W-1:0] o_result
);
    localparam int AW = crs_pkg::ACC_W;
    localparam int PW = crs_pkg::ACC_W + crs_pkg::T_W + 1;

    logic signed [AW-1:0] r_p0, r_p1, r_p2, r_p3;
    logic signed [AW-1:0] r_a, r_b, r_d, r_r;
    logic signed [PW-1:0] r_prod;
    logic signed [AW-1:0] c_val, b_val, a_val, add_val, v;
    logic signed [PW-1:0] rnd;
    logic signed [AW-1:0] sat_hi, sat_lo;

    // coefficients of the uniform cubic
    always_comb begin
        a_val = r_p2 - r_p0;
        b_val = (r_p0 <<< 1) - (r_p1 <<< 2) - r_p1 + (r_p2 <<< 2) - r_p3;
        c_val = r_p3 - r_p0 + (r_p1 <<< 1) + r_p1 - (r_p2 <<< 1) - r_p2;
    end

    // round half up of prod / 65536, then add the step coefficient
    always_comb begin
        rnd = (r_prod + PW'(32768)) >>> 16;
        case (i_ctl.step)
            crs_pkg::STEP_B:  add_val = r_b;
            crs_pkg::STEP_A:  add_val = r_a;
            crs_pkg::STEP_P1: add_val = r_d;
            default:          add_val = r_d;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_p0 <= r_p1;
            r_p1 <= r_p2;
            r_p2 <= r_p3;
            r_p3 <= AW'(i_point);
        end
        if (i_ctl.coef) begin
            r_a <= a_val;
            r_b <= b_val;
            r_d <= r_p1 <<< 1;
            r_r <= c_val;
        end
        if (i_ctl.mul) begin
            r_prod <= r_r * $signed({1'b0, i_t});
        end
        if (i_ctl.acc) begin
            r_r <= rnd[AW-1:0] + add_val;
        end
    end

    // halve with half-up rounding and saturate
    always_comb begin
        v      = (r_r + AW'(1)) >>> 1;
        sat_hi = AW'({1'b0, {(crs_pkg::COORD_W-1){1'b1}}});
        sat_lo = -sat_hi - AW'(1);
        if (v > sat_hi) begin
            o_result = sat_hi[crs_pkg::COORD_W-1:0];
        end else if (v < sat_lo) begin
            o_result = sat_lo[crs_pkg::COORD_W-1:0];
        end else begin
            o_result = v[crs_pkg::COORD_W-1:0];
        end
    end
endmodule
`default_nettype wire

### src/catmull_rom_curve_sampler.sv
// Top level: point loading, sample sequencing, three axis lanes and output merge.
//
//  channel  | dir | handshake                       | payload
//  ---------+-----+---------------------------------+---------------------
//  in       | in  | i_in_valid / o_in_ready         | i_in_beat  (t_in_beat)
//  out      | out | o_out_valid / i_out_ready       | o_out_beat (t_out_beat)
//  cfg      | in  | i_cfg_we                        | i_cfg_idx, i_cfg_data
//
// Load and no-op beats leave the sequencer idle. A spline result is registered
// after the serial t divider, run beside the store reads, then coefficients and
// three Horner steps, each a multiply and an accumulate state. A raw point follows
// its store read and an exhausted answer needs none; the input reopens with the result.
// Synchronous reset clears counters and sequencer; the point store is not reset.
// A held result stalls the input only once the next result is ready to leave.
`default_nettype none
module catmull_rom_curve_sampler (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  wire crs_pkg::t_in_beat i_in_beat,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output crs_pkg::t_out_beat  o_out_beat,
    input  wire                 i_cfg_we,
    input  wire                 i_cfg_idx,
    input  wire  [5:0]          i_cfg_data
);
    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_READ = 7'b0000010,
        ST_WAIT = 7'b0000100,
        ST_COEF = 7'b0001000,
        ST_MUL  = 7'b0010000,
        ST_ACC  = 7'b0100000,
        ST_OUT  = 7'b1000000
    } t_state;

    typedef enum logic [2:0] {
        K_EXH    = 3'b001,
        K_RAW    = 3'b010,
        K_SPLINE = 3'b100
    } t_kind;

    localparam int CW = crs_pkg::CNT_W;
    localparam int AW = crs_pkg::ADDR_W;

    t_state r_state, n_state;
    t_kind  r_kind, n_kind;

    logic          r_closed;
    logic [5:0]    r_sps;
    logic [CW-1:0] r_count, r_seg, n_seg;
    logic [5:0]    r_samp, n_samp;
    logic          r_fin, n_fin;
    logic          r_last, n_last;
    logic [AW-1:0] r_idx [4];
    logic [AW-1:0] n_idx [4];
    logic [1:0]    r_rd;
    logic          r_rd_vld;
    logic [1:0]    r_step;
    logic          r_out_valid;
    crs_pkg::t_out_beat r_out;

    logic          acc_in, is_load, is_sample, room;
    logic [5:0]    s_eff, k_eff;
    logic          few, wrap;
    logic [CW-1:0] g, segc, g1, g2;
    logic [6:0]    k1;
    logic          div_start, div_busy;
    logic [crs_pkg::T_W-1:0] div_q;
    logic          rd_en;
    logic          st_we;
    logic [AW-1:0] st_waddr;
    crs_pkg::t_point st_wdata, st_rdata;
    crs_pkg::t_lane_ctl lane_ctl;
    logic signed [crs_pkg::COORD_W-1:0] res_x, res_y, res_z;

    assign o_in_ready = (r_state == ST_IDLE);
    assign acc_in     = i_in_valid && o_in_ready;
    assign is_load    = i_in_beat.opcode inside {crs_pkg::OP_START, crs_pkg::OP_APPEND};
    assign is_sample  = (i_in_beat.opcode == crs_pkg::OP_SAMPLE);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_closed <= 1'b0;
            r_sps    <= 6'd8;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                crs_pkg::CFG_CLOSED: r_closed <= i_cfg_data[0];
                crs_pkg::CFG_SPS:    r_sps    <= i_cfg_data;
                default:             r_sps    <= r_sps;
            endcase
        end
    end

    // point store writes
    assign room     = (r_count < CW'(crs_pkg::MAX_POINTS));
    assign st_we    = acc_in && is_load &&
                      ((i_in_beat.opcode == crs_pkg::OP_START) || room);
    assign st_waddr = (i_in_beat.opcode == crs_pkg::OP_START) ? '0 : r_count[AW-1:0];
    assign st_wdata = '{x: i_in_beat.point_x, y: i_in_beat.point_y, z: i_in_beat.point_z};

    // sample decision, from the state left by the previous beat
    always_comb begin
        if (r_sps < 6'd2) begin
            s_eff = 6'd2;
        end else if (r_sps > 6'(crs_pkg::MAX_SEG_SMP)) begin
            s_eff = 6'(crs_pkg::MAX_SEG_SMP);
        end else begin
            s_eff = r_sps;
        end
        few   = (r_count < CW'(2)) || (r_closed && (r_count < CW'(3)));
        wrap  = (r_samp >= s_eff);
        g     = wrap ? (r_seg + CW'(1)) : r_seg;
        k_eff = wrap ? 6'd0 : r_samp;
        segc  = r_closed ? r_count : (r_count - CW'(1));
        k1    = {1'b0, k_eff} + 7'd1;
        g1    = g + CW'(1);
        g2    = g + CW'(2);

        n_kind = K_EXH;
        n_seg  = r_seg;
        n_samp = r_samp;
        n_fin  = r_fin;
        n_last = 1'b0;
        for (int i = 0; i < 4; i++) begin
            n_idx[i] = r_idx[i];
        end

        if (r_fin) begin
            n_kind = K_EXH;
        end else if (few) begin
            if (r_seg >= r_count) begin
                n_fin = 1'b1;
            end else begin
                n_kind   = K_RAW;
                n_idx[3] = r_seg[AW-1:0];
                n_last   = (r_seg == r_count - CW'(1));
                n_seg    = r_seg + CW'(1);
                n_fin    = n_last;
            end
        end else if (g < segc) begin
            n_kind   = K_SPLINE;
            n_idx[1] = g[AW-1:0];
            if (r_closed) begin
                n_idx[0] = (g == '0) ? AW'(r_count - CW'(1)) : AW'(g - CW'(1));
                n_idx[2] = (g1 == r_count) ? '0 : g1[AW-1:0];
                n_idx[3] = (g2 >= r_count) ? AW'(g2 - r_count) : g2[AW-1:0];
            end else begin
                n_idx[0] = (g == '0) ? '0 : AW'(g - CW'(1));
                n_idx[2] = g1[AW-1:0];
                n_idx[3] = (g2 < r_count - CW'(1)) ? g2[AW-1:0] : AW'(r_count - CW'(1));
            end
            n_last = r_closed && (g == segc - CW'(1)) && (k1 == {1'b0, s_eff});
            if (k1 >= {1'b0, s_eff}) begin
                n_samp = 6'd0;
                n_seg  = g1;
            end else begin
                n_samp = k1[5:0];
                n_seg  = g;
            end
            n_fin = n_last;
        end else if (!r_closed && (g == segc)) begin
            n_kind   = K_RAW;
            n_idx[3] = AW'(r_count - CW'(1));
            n_last   = 1'b1;
            n_fin    = 1'b1;
            n_seg    = g;
            n_samp   = k_eff;
        end else begin
            n_fin  = 1'b1;
            n_seg  = g;
            n_samp = k_eff;
        end
    end

    assign div_start = acc_in && is_sample && (n_kind == K_SPLINE);

    // curve state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_seg   <= '0;
            r_samp  <= '0;
            r_fin   <= 1'b0;
        end else if (acc_in && is_load) begin
            if (i_in_beat.opcode == crs_pkg::OP_START) begin
                r_count <= CW'(1);
            end else if (room) begin
                r_count <= r_count + CW'(1);
            end
            r_seg  <= '0;
            r_samp <= '0;
            r_fin  <= 1'b0;
        end else if (acc_in && is_sample) begin
            r_seg  <= n_seg;
            r_samp <= n_samp;
            r_fin  <= n_fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_in && is_sample) begin
            r_kind <= n_kind;
            r_last <= n_last;
            for (int i = 0; i < 4; i++) begin
                r_idx[i] <= n_idx[i];
            end
        end
    end

    // sequencer
    assign rd_en = (r_state == ST_READ);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (acc_in && is_sample) begin
                    n_state = (n_kind == K_EXH) ? ST_OUT : ST_READ;
                end
            end
            ST_READ: if (r_rd == 2'd3) n_state = ST_WAIT;
            ST_WAIT: begin
                if (!r_rd_vld) begin
                    if (r_kind == K_RAW) begin
                        n_state = ST_OUT;
                    end else if (!div_busy) begin
                        n_state = ST_COEF;
                    end
                end
            end
            ST_COEF: n_state = ST_MUL;
            ST_MUL:  n_state = ST_ACC;
            ST_ACC:  n_state = (r_step == crs_pkg::STEP_P1) ? ST_OUT : ST_MUL;
            ST_OUT:  if (!r_out_valid || i_out_ready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= rd_en;
        end
    end

    // read slot counter and Horner step counter
    always_ff @(posedge i_clk) begin
        if (acc_in) begin
            r_rd <= (n_kind == K_SPLINE) ? 2'd0 : 2'd3;
        end else if (rd_en) begin
            r_rd <= r_rd + 2'd1;
        end
        if (r_state == ST_COEF) begin
            r_step <= crs_pkg::STEP_B;
        end else if (r_state == ST_ACC) begin
            r_step <= r_step + 2'd1;
        end
    end

    crs_store u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_re    (rd_en),
        .i_raddr (r_idx[r_rd]),
        .o_rdata (st_rdata)
    );

    crs_tdiv u_tdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_k     (k_eff),
        .i_s     (s_eff),
        .o_q     (div_q),
        .o_busy  (div_busy)
    );

    // lane control, shared by all three lanes
    always_comb begin
        lane_ctl.shift = r_rd_vld;
        lane_ctl.coef  = (r_state == ST_COEF);
        lane_ctl.mul   = (r_state == ST_MUL);
        lane_ctl.acc   = (r_state == ST_ACC);
        lane_ctl.step  = r_step;
    end

    crs_lane u_lane_x (
        .i_clk (i_clk), .i_ctl (lane_ctl), .i_point (st_rdata.x),
        .i_t (div_q), .o_result (res_x)
    );
    crs_lane u_lane_y (
        .i_clk (i_clk), .i_ctl (lane_ctl), .i_point (st_rdata.y),
        .i_t (div_q), .o_result (res_y)
    );
    crs_lane u_lane_z (
        .i_clk (i_clk), .i_ctl (lane_ctl), .i_point (st_rdata.z),
        .i_t (div_q), .o_result (res_z)
    );

    // merge lanes into the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_OUT) && (!r_out_valid || i_out_ready)) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_OUT) && (!r_out_valid || i_out_ready)) begin
            case (r_kind)
                K_RAW: begin
                    r_out.sample_x <= st_rdata.x;
                    r_out.sample_y <= st_rdata.y;
                    r_out.sample_z <= st_rdata.z;
                    r_out.last_sample <= r_last;
                    r_out.exhausted   <= 1'b0;
                end
                K_SPLINE: begin
                    r_out.sample_x <= res_x;
                    r_out.sample_y <= res_y;
                    r_out.sample_z <= res_z;
                    r_out.last_sample <= r_last;
                    r_out.exhausted   <= 1'b0;
                end
                default: begin
                    r_out <= '{sample_x: '0, sample_y: '0, sample_z: '0,
                               last_sample: 1'b0, exhausted: 1'b1};
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;
endmodule
`default_nettype wire

### src/crs_checker.sv
// Port-level checks of the curve sampler, bound to the top level.
`default_nettype none
module crs_checker (
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 o_out_valid,
    input wire                 i_out_ready,
    input wire crs_pkg::t_out_beat o_out_beat
);
    // a stalled result beat stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result beat dropped while stalled");

    // an exhausted beat carries zero coordinates and no last flag
    a_exh_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_beat.exhausted |->
            o_out_beat.sample_x == 0 && o_out_beat.sample_y == 0 &&
            o_out_beat.sample_z == 0 && !o_out_beat.last_sample)
        else $error("exhausted beat with payload");

    // reset leaves no result pending
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");
endmodule

bind catmull_rom_curve_sampler crs_checker u_crs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_beat  (o_out_beat)
);
`default_nettype wire
